// File: rtl/stable_priority_queue_with_delete_assert.svh
// Assertion macro used by the queue checker.
`ifndef STABLE_PRIORITY_QUEUE_WITH_DELETE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_WITH_DELETE_ASSERT_SVH

// Labeled assertion on clk, disabled while reset is held, reporting through $error.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRIO_W   = 8;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_POP      = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_RESERVED = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_POPPED    = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_REMOVED   = 3'd4,
    STAT_NOT_FOUND = 3'd5,
    STAT_FULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CMP,
    OP_INS,
    OP_DEL,
    OP_POP
  } cell_op_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    cell_op_t            op;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
  } cell_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                valid;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   prio;
    logic                ge;
    logic                past;
  } cell_link_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_cmd_t  cmd,
  input  spq_pkg::cell_link_t left_in,
  input  spq_pkg::cell_link_t right_in,
  output spq_pkg::cell_link_t self_out
);

  logic                          valid_r, valid_nxt;
  logic [spq_pkg::ID_W-1:0]      id_r, id_nxt;
  logic [spq_pkg::PRIO_W-1:0]    prio_r, prio_nxt;
  logic                          match_r, match_nxt;
  logic                          ge_r, ge_nxt;
  logic                          past;

  // Propagate "removal point at or before here" down the row
  assign past = left_in.past | match_r;

  assign self_out.valid = valid_r;
  assign self_out.id    = id_r;
  assign self_out.prio  = prio_r;
  assign self_out.ge    = ge_r;
  assign self_out.past  = past;

  // Compare, insert or shift
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    match_nxt = match_r;
    ge_nxt    = ge_r;
    case (cmd.op)
      spq_pkg::OP_CMP: begin
        match_nxt = valid_r && (id_r == cmd.id);
        ge_nxt    = valid_r && (prio_r >= cmd.prio);
      end
      spq_pkg::OP_INS: begin
        if (!ge_r) begin
          if (left_in.ge) begin
            valid_nxt = 1'b1;
            id_nxt    = cmd.id;
            prio_nxt  = cmd.prio;
          end else begin
            valid_nxt = left_in.valid;
            id_nxt    = left_in.id;
            prio_nxt  = left_in.prio;
          end
        end
      end
      spq_pkg::OP_DEL: begin
        if (past) begin
          valid_nxt = right_in.valid;
          id_nxt    = right_in.id;
          prio_nxt  = right_in.prio;
        end
      end
      spq_pkg::OP_POP: begin
        valid_nxt = right_in.valid;
        id_nxt    = right_in.id;
        prio_nxt  = right_in.prio;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      ge_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
      ge_r    <= ge_nxt;
    end
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

endmodule

// File: rtl/stable_priority_queue_with_delete.sv
// A request is registered when taken, compared across all cells in S_CMP, and its
// result registered when the row shift commits in S_UPD; a new request is taken
// as the shift commits, and a stalled result holds the shift.
// Reset (synchronous, rst_n low) empties the queue and drops any pending result.
// No clearing pass: the queue takes requests as soon as reset is released.
module stable_priority_queue_with_delete (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [spq_pkg::ID_W-1:0]      in_entry_id,
  input  logic [spq_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [spq_pkg::ID_W-1:0]      out_id
);

  spq_pkg::state_t                 state_r, state_nxt;
  spq_pkg::req_type_t              req_type_r;
  logic [spq_pkg::ID_W-1:0]        req_id_r;
  logic [spq_pkg::PRIO_W-1:0]      req_prio_r;
  logic                            out_valid_r;
  spq_pkg::status_t                out_status_r, status_nxt;
  logic [spq_pkg::ID_W-1:0]        out_id_r, id_nxt;

  spq_pkg::cell_cmd_t              cmd;
  spq_pkg::cell_op_t               upd_op;
  spq_pkg::cell_link_t             cell_out [spq_pkg::CAPACITY];
  spq_pkg::cell_link_t             left_in  [spq_pkg::CAPACITY];
  spq_pkg::cell_link_t             right_in [spq_pkg::CAPACITY];
  spq_pkg::cell_link_t             edge_left, edge_right;

  logic commit;
  logic in_fire;
  logic any_match;
  logic empty;
  logic full;

  // Row boundaries: nothing ahead of the head, empty beyond the tail
  always_comb begin
    edge_left       = '0;
    edge_left.ge    = 1'b1;
    edge_right      = '0;
  end

  // Wire the row of cells
  for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_in[g] = edge_left;
    end else begin : g_mid
      assign left_in[g] = cell_out[g-1];
    end
    if (g == spq_pkg::CAPACITY - 1) begin : g_tail
      assign right_in[g] = edge_right;
    end else begin : g_body
      assign right_in[g] = cell_out[g+1];
    end
    spq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .left_in  (left_in[g]),
      .right_in (right_in[g]),
      .self_out (cell_out[g])
    );
  end

  assign any_match = cell_out[spq_pkg::CAPACITY-1].past;
  assign empty     = !cell_out[0].valid;
  assign full      = cell_out[spq_pkg::CAPACITY-1].valid;

  assign commit   = (state_r == spq_pkg::S_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == spq_pkg::S_IDLE) || commit;
  assign in_fire  = in_valid && in_ready;

  // Decide the outcome and the row operation
  always_comb begin
    upd_op     = spq_pkg::OP_NONE;
    status_nxt = spq_pkg::STAT_NOT_FOUND;
    id_nxt     = req_id_r;
    case (req_type_r)
      spq_pkg::REQ_INSERT: begin
        if (any_match) begin
          status_nxt = spq_pkg::STAT_DUPLICATE;
        end else if (full) begin
          status_nxt = spq_pkg::STAT_FULL;
        end else begin
          status_nxt = spq_pkg::STAT_INSERTED;
          upd_op     = spq_pkg::OP_INS;
        end
      end
      spq_pkg::REQ_POP: begin
        if (empty) begin
          status_nxt = spq_pkg::STAT_EMPTY;
        end else begin
          status_nxt = spq_pkg::STAT_POPPED;
          id_nxt     = cell_out[0].id;
          upd_op     = spq_pkg::OP_POP;
        end
      end
      spq_pkg::REQ_REMOVE: begin
        if (any_match) begin
          status_nxt = spq_pkg::STAT_REMOVED;
          upd_op     = spq_pkg::OP_DEL;
        end
      end
      default: begin
      end
    endcase
  end

  // Broadcast to the cells
  always_comb begin
    cmd.id   = req_id_r;
    cmd.prio = req_prio_r;
    if (state_r == spq_pkg::S_CMP) begin
      cmd.op = spq_pkg::OP_CMP;
    end else if (commit) begin
      cmd.op = upd_op;
    end else begin
      cmd.op = spq_pkg::OP_NONE;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = spq_pkg::S_CMP;
      end
      spq_pkg::S_CMP: begin
        state_nxt = spq_pkg::S_UPD;
      end
      spq_pkg::S_UPD: begin
        if (commit) state_nxt = in_valid ? spq_pkg::S_CMP : spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r <= spq_pkg::req_type_t'(in_req_type);
      req_id_r   <= in_entry_id;
      req_prio_r <= in_priority_req;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (commit) begin
      out_status_r <= status_nxt;
      out_id_r     <= id_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;

endmodule

// File: rtl/spq_checker.sv
`include "stable_priority_queue_with_delete_assert.svh"

module spq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [spq_pkg::ID_W-1:0]      in_entry_id,
  input  logic [spq_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [2:0]                    out_status,
  input  logic [spq_pkg::ID_W-1:0]      out_id
);

  logic                                        in_fire;
  logic                                        in_wait;
  logic                                        out_wait;
  logic [2+spq_pkg::ID_W+spq_pkg::PRIO_W-1:0]  in_word;
  logic [3+spq_pkg::ID_W-1:0]                  out_word;

  assign in_fire  = in_valid && in_ready;
  assign in_wait  = in_valid && !in_ready;
  assign out_wait = out_valid && !out_ready;
  assign in_word  = {in_req_type, in_entry_id, in_priority_req};
  assign out_word = {out_status, out_id};

  `SPQ_ASSERT(a_status_code, out_valid |-> (out_status <= spq_pkg::STAT_FULL), "bad status code")
  `SPQ_ASSERT(a_one_at_a_time, in_fire |=> !in_ready, "request taken during compare")
  `SPQ_ASSERT(a_result_holds, out_wait |=> (out_valid && $stable(out_word)), "result changed")
  `SPQ_ASSERT(a_request_holds, in_wait |=> (in_valid && $stable(in_word)), "request changed")

endmodule

bind stable_priority_queue_with_delete spq_checker u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_req_type     (in_req_type),
  .in_entry_id     (in_entry_id),
  .in_priority_req (in_priority_req),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_id          (out_id)
);

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 1620;

  typedef logic [spq_pkg::ID_W-1:0]   id_t;
  typedef logic [spq_pkg::PRIO_W-1:0] prio_t;

  typedef struct {
    spq_pkg::req_type_t kind;
    id_t                id;
    prio_t              prio;
    bit                 wait_drain;
  } request_t;

  typedef struct {
    spq_pkg::status_t status;
    id_t              id;
  } answer_t;

  // Contents of the queue, head at index 0
  typedef struct {
    id_t   ids[spq_pkg::CAPACITY];
    prio_t prios[spq_pkg::CAPACITY];
    int    count;
  } spq_image_t;

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = '0;
  id_t        in_entry_id = '0;
  prio_t      in_priority_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  id_t        out_id;

  request_t   request_q[$];
  answer_t    answer_q[$];
  spq_image_t plan_image;
  spq_image_t live_image;

  int       cycles = 0;
  int       mismatch_cnt = 0;
  int       taken_cnt = 0;
  int       handed_cnt = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  stable_priority_queue_with_delete u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_entry_id     (in_entry_id),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id)
  );

  // Close the gap left by the entry at pos
  function automatic void drop_entry(ref spq_image_t q, input int pos);
    int i;
    for (i = pos; i + 1 < q.count; i++) begin
      q.ids[i]   = q.ids[i + 1];
      q.prios[i] = q.prios[i + 1];
    end
    q.count--;
  endfunction

  // Apply one request to a queue image and work out its answer
  function automatic void serve_request(ref spq_image_t q, input request_t r,
                                        output answer_t a);
    int i;
    int hit;
    int pos;
    hit = -1;
    a.id = r.id;
    for (i = 0; i < q.count; i++) begin
      if (hit < 0 && q.ids[i] == r.id) hit = i;
    end
    case (r.kind)
      spq_pkg::REQ_INSERT: begin
        if (hit >= 0) begin
          a.status = spq_pkg::STAT_DUPLICATE;
        end else if (q.count >= spq_pkg::CAPACITY) begin
          a.status = spq_pkg::STAT_FULL;
        end else begin
          // Equal priorities keep arrival order: go behind them
          pos = 0;
          while (pos < q.count && q.prios[pos] >= r.prio) pos++;
          for (i = q.count; i > pos; i--) begin
            q.ids[i]   = q.ids[i - 1];
            q.prios[i] = q.prios[i - 1];
          end
          q.ids[pos]   = r.id;
          q.prios[pos] = r.prio;
          q.count++;
          a.status = spq_pkg::STAT_INSERTED;
        end
      end
      spq_pkg::REQ_POP: begin
        if (q.count == 0) begin
          a.status = spq_pkg::STAT_EMPTY;
        end else begin
          a.id = q.ids[0];
          drop_entry(q, 0);
          a.status = spq_pkg::STAT_POPPED;
        end
      end
      spq_pkg::REQ_REMOVE: begin
        if (hit >= 0) begin
          drop_entry(q, hit);
          a.status = spq_pkg::STAT_REMOVED;
        end else begin
          a.status = spq_pkg::STAT_NOT_FOUND;
        end
      end
      default: a.status = spq_pkg::STAT_NOT_FOUND;
    endcase
  endfunction

  // Queue a request and track what the queue will hold after it
  task automatic add_request(input spq_pkg::req_type_t kind, input id_t id,
                             input prio_t prio, input bit wait_drain);
    request_t r;
    answer_t  a;
    r.kind       = kind;
    r.id         = id;
    r.prio       = prio;
    r.wait_drain = wait_drain;
    request_q.push_back(r);
    serve_request(plan_image, r, a);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatch_cnt++;
  endtask

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL stable_priority_queue_with_delete");
      $finish;
    end
  end

  // Drive requests in bursts; a marked request waits for all answers first
  always @(negedge clk) begin
    request_t nxt;
    logic     offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_cnt == handed_cnt) begin
      // hold the request until it is taken
    end else begin
      handed_cnt = taken_cnt;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_q.size() > 0 &&
                   !(request_q[0].wait_drain && answer_q.size() > 0)) begin
        nxt = request_q.pop_front();
        offer = 1'b1;
        in_req_type     <= nxt.kind;
        in_entry_id     <= nxt.id;
        in_priority_req <= nxt.prio;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= offer;
    end
  end

  // Result side: long hold-offs now and then, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (cycles % 2000 == 700) begin
      hold_left = 160;
      out_ready <= 1'b0;
    end else begin
      if (cycles % 50 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= cycles[0];
      endcase
    end
  end

  // Check each answer against the oldest prediction, then predict for a new request
  always @(posedge clk) begin
    request_t got;
    answer_t  want;
    answer_t  fresh;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("answer with no request outstanding", 32'(out_status), 32'd0);
        end else begin
          want = answer_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_id !== want.id) report_mismatch("id", 32'(out_id), 32'(want.id));
        end
      end
      if (in_valid && in_ready) begin
        got.kind       = spq_pkg::req_type_t'(in_req_type);
        got.id         = in_entry_id;
        got.prio       = in_priority_req;
        got.wait_drain = 1'b0;
        serve_request(live_image, got, fresh);
        answer_q.push_back(fresh);
        taken_cnt++;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int    n;
    int    roll;
    int    fill_bias;
    id_t   pool_base;
    id_t   id;
    prio_t prio;

    plan_image.count = 0;
    live_image.count = 0;

    // Empty queue cases and the reserved selector
    add_request(spq_pkg::REQ_POP,      16'hFFFF, 8'hFF, 1'b0);
    add_request(spq_pkg::REQ_REMOVE,   16'h0000, 8'h00, 1'b0);
    add_request(spq_pkg::REQ_RESERVED, 16'hA5A5, 8'h5A, 1'b0);
    // Extremes of id and priority, a tie at the top, a duplicate, then one remove that hits and one that misses
    add_request(spq_pkg::REQ_INSERT,   16'h0000, 8'h00, 1'b0);
    add_request(spq_pkg::REQ_INSERT,   16'hFFFF, 8'hFF, 1'b0);
    add_request(spq_pkg::REQ_INSERT,   16'h1234, 8'hFF, 1'b0);
    add_request(spq_pkg::REQ_INSERT,   16'h0000, 8'h07, 1'b0);
    add_request(spq_pkg::REQ_INSERT,   16'h5555, 8'h80, 1'b0);
    add_request(spq_pkg::REQ_REMOVE,   16'h5555, 8'h00, 1'b0);
    add_request(spq_pkg::REQ_REMOVE,   16'h5555, 8'h00, 1'b0);
    // Fill to capacity with equal priorities, then overflow
    for (n = 0; n < 13; n++)
      add_request(spq_pkg::REQ_INSERT, id_t'(16'h0100 + n), 8'd77, 1'b0);
    add_request(spq_pkg::REQ_INSERT,   16'hBEEF, 8'hC8, 1'b0);
    // Duplicate check wins over full
    add_request(spq_pkg::REQ_INSERT,   16'h0000, 8'h01, 1'b0);
    add_request(spq_pkg::REQ_POP,      16'h0F0F, 8'h00, 1'b0);
    add_request(spq_pkg::REQ_POP,      16'hF0F0, 8'h00, 1'b0);
    add_request(spq_pkg::REQ_POP,      16'h0000, 8'h00, 1'b0);

    // Random traffic; the bias swings the queue between empty and full
    fill_bias = 50;
    pool_base = '0;
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0) begin
        fill_bias = $urandom_range(10, 90);
        pool_base = id_t'($urandom);
      end
      if ($urandom_range(0, 4) == 0) id = id_t'($urandom);
      else id = pool_base ^ id_t'($urandom_range(0, 23));
      if ($urandom_range(0, 9) < 6) prio = prio_t'($urandom_range(0, 3) * 85);
      else prio = prio_t'($urandom);
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) begin
        add_request(spq_pkg::REQ_RESERVED, id_t'($urandom), prio_t'($urandom),
                    n % 400 == 399);
      end else if (roll < fill_bias) begin
        add_request(spq_pkg::REQ_INSERT, id, prio, n % 400 == 399);
      end else if (roll < fill_bias + (100 - fill_bias) / 2) begin
        add_request(spq_pkg::REQ_POP, id_t'($urandom), prio_t'($urandom),
                    n % 400 == 399);
      end else begin
        // Mostly remove an entry that is present
        if (plan_image.count > 0 && $urandom_range(0, 9) < 7)
          id = plan_image.ids[$urandom_range(0, plan_image.count - 1)];
        add_request(spq_pkg::REQ_REMOVE, id, prio_t'($urandom), n % 400 == 399);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every request to go out and every answer to come back
    while (request_q.size() > 0 || in_valid) @(posedge clk);
    while (answer_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("PASS stable_priority_queue_with_delete");
    end else begin
      $display("FAIL stable_priority_queue_with_delete");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_with_delete.sv
rtl/spq_checker.sv
tb/tb_top.sv
